[hw/rtl/pal_pkg.sv]
package pal_pkg;

  // Size of the graph being grown.
  localparam int NODES    = 64;

  localparam int IDX_W    = $clog2(NODES);
  localparam int NODE_W   = $clog2(NODES + 1);
  localparam int DEG_W    = 7;
  localparam int CFG_W    = 7;
  localparam int FRAC_W   = 16;
  localparam int OUT_W    = 6;
  localparam int TOT_W    = $clog2(NODES * 127 + 1);
  localparam int PROD_W   = TOT_W + FRAC_W;
  localparam int ENT_W    = NODE_W + DEG_W;
  localparam int CMP_W    = (NODE_W > CFG_W) ? NODE_W : CFG_W;

  localparam logic [DEG_W-1:0]  DEG_MAX   = 7'd127;
  localparam logic [CFG_W-1:0]  SEED_HI   = CFG_W'((NODES < 64) ? NODES : 64);
  localparam logic [CFG_W-1:0]  SEED_LO   = 7'd2;
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NODES - 1);
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);
  localparam logic [NODE_W-1:0] NODE_END  = NODE_W'(NODES);

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_DRAW  = 1'b1;

  localparam logic CFG_SEED_NODES     = 1'b0;
  localparam logic CFG_LINKS_PER_NODE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SUM,
    ST_SUM_TAIL,
    ST_CHECK,
    ST_FIND,
    ST_FIND_TAIL,
    ST_RD_CH,
    ST_WR_CH,
    ST_RD_CUR,
    ST_WR_CUR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;       // capture the fraction of an accepted item
    logic init_sum;   // restart address counter and total
    logic init_find;  // restart address counter and running sum
    logic clr_step;   // write one entry of the seed sweep
    logic issue;      // read the entry at the address counter
    logic acc_sum;    // add the returned entry into the total
    logic mul;        // form fraction times total
    logic acc_find;   // add the returned entry into the running sum
    logic rd_ch;      // read the chosen node
    logic wr_ch;      // write back the chosen node
    logic rd_cur;     // read the node being attached
    logic wr_cur;     // write back the node being attached
    logic open_seed;  // first node after the seed clique becomes current
    logic open_next;  // move on to the next node without a link
    logic emit;       // load the output register
  } cmd_t;

  typedef struct packed {
    logic addr_last;
    logic done;
    logic any;
    logic found;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/pal_ram.sv]
module pal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/pal_ctrl.sv]
module pal_ctrl
  import pal_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tuser,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = (state_r == ST_IDLE) && in_tvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == MODE_START) begin
            state_nxt = ST_CLR;
          end else if (!sts.done) begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_CLR: begin
        if (sts.addr_last) state_nxt = ST_IDLE;
      end
      ST_SUM: begin
        if (sts.addr_last) state_nxt = ST_SUM_TAIL;
      end
      ST_SUM_TAIL:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = sts.any ? ST_FIND : ST_IDLE;
      end
      ST_FIND: begin
        if (sts.found) begin
          state_nxt = ST_RD_CH;
        end else if (sts.addr_last) begin
          state_nxt = ST_FIND_TAIL;
        end
      end
      ST_FIND_TAIL: state_nxt = ST_RD_CH;
      ST_RD_CH:     state_nxt = ST_WR_CH;
      ST_WR_CH:     state_nxt = ST_RD_CUR;
      ST_RD_CUR:    state_nxt = ST_WR_CUR;
      ST_WR_CUR:    state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.load     = accept;
        cmd.init_sum = accept;
      end
      ST_CLR: begin
        cmd.clr_step  = 1'b1;
        cmd.open_seed = sts.addr_last;
      end
      ST_SUM: begin
        cmd.issue   = 1'b1;
        cmd.acc_sum = 1'b1;
      end
      ST_SUM_TAIL: cmd.acc_sum = 1'b1;
      ST_CHECK: begin
        cmd.mul       = sts.any;
        cmd.init_find = sts.any;
        cmd.open_next = !sts.any;
      end
      ST_FIND: begin
        cmd.issue    = 1'b1;
        cmd.acc_find = 1'b1;
      end
      ST_FIND_TAIL: cmd.acc_find = 1'b1;
      ST_RD_CH:     cmd.rd_ch    = 1'b1;
      ST_WR_CH:     cmd.wr_ch    = 1'b1;
      ST_RD_CUR:    cmd.rd_cur   = 1'b1;
      ST_WR_CUR:    cmd.wr_cur   = 1'b1;
      ST_EMIT:      cmd.emit     = sts.out_free;
      default:      cmd          = '0;
    endcase
  end

endmodule

[hw/rtl/pal_dp.sv]
module pal_dp
  import pal_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [FRAC_W-1:0] frac_in,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_new,
  output logic [OUT_W-1:0]  out_chosen,
  output logic              out_last,
  input  logic              out_ready
);

  // Configuration.
  logic [CFG_W-1:0]  seed_r, seed_nxt;
  logic [CFG_W-1:0]  links_r, links_nxt;

  // Graph progress.
  logic [NODE_W-1:0] current_r, current_nxt;
  logic [CFG_W-1:0]  made_r, made_nxt;
  logic              done_r, done_nxt;

  // Scan datapath.
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic              any_r, any_nxt;
  logic [IDX_W-1:0]  last_cand_r, last_cand_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [TOT_W-1:0]  cum_r, cum_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  found_idx_r, found_idx_nxt;
  logic [IDX_W-1:0]  chosen_r, chosen_nxt;

  // Output register.
  logic              out_vld_r, out_vld_nxt;
  logic [OUT_W-1:0]  out_new_r, out_new_nxt;
  logic [OUT_W-1:0]  out_chosen_r, out_chosen_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory port.
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  logic [DEG_W-1:0]  rd_deg, deg_inc;
  logic [NODE_W-1:0] rd_tag;
  logic              cand;
  logic [TOT_W-1:0]  cum_add;
  logic [CFG_W-1:0]  seed_eff, links_eff, links_s;
  logic [CFG_W-1:0]  made_inc;
  logic              node_full;

  pal_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NODES)
  ) u_deg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_deg  = ram_rdata[DEG_W-1:0];
  assign rd_tag  = ram_rdata[ENT_W-1:DEG_W];
  assign deg_inc = (rd_deg == DEG_MAX) ? DEG_MAX : rd_deg + 1'b1;

  // An entry is a candidate if it is an earlier node and was not linked to the
  // current node; the tag holds the last node that linked to it.
  assign cand = rd_vld_r && (NODE_W'(rd_idx_r) < current_r) && (rd_tag != current_r);
  assign cum_add = cum_r + TOT_W'(rd_deg);

  always_comb begin
    seed_eff = seed_r;
    if (seed_r < SEED_LO) seed_eff = SEED_LO;
    if (seed_r > SEED_HI) seed_eff = SEED_HI;
  end

  always_comb begin
    links_s = (links_r == '0) ? CFG_W'(1) : links_r;
    if (links_s > seed_eff) links_s = seed_eff;
    links_eff = links_s;
    if (CMP_W'(current_r) < CMP_W'(links_s)) links_eff = CFG_W'(current_r);
    if (links_eff == '0) links_eff = CFG_W'(1);
  end

  assign made_inc  = made_r + 1'b1;
  assign node_full = made_inc >= links_eff;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = addr_r;
    if (cmd.clr_step) begin
      ram_we    = 1'b1;
      ram_wdata = {NODE_W'(0),
                   (CMP_W'(addr_r) < CMP_W'(seed_eff)) ? seed_eff - 1'b1 : DEG_W'(0)};
    end
    if (cmd.wr_ch) begin
      ram_we    = 1'b1;
      ram_waddr = chosen_r;
      ram_wdata = {current_r, deg_inc};
    end
    if (cmd.wr_cur) begin
      ram_we    = 1'b1;
      ram_waddr = current_r[IDX_W-1:0];
      ram_wdata = {rd_tag, deg_inc};
    end
    if (cmd.issue) begin
      ram_re = 1'b1;
    end
    if (cmd.rd_ch) begin
      ram_re    = 1'b1;
      ram_raddr = chosen_nxt;
    end
    if (cmd.rd_cur) begin
      ram_re    = 1'b1;
      ram_raddr = current_r[IDX_W-1:0];
    end
  end

  always_comb begin
    seed_nxt      = seed_r;
    links_nxt     = links_r;
    current_nxt   = current_r;
    made_nxt      = made_r;
    done_nxt      = done_r;
    frac_nxt      = frac_r;
    addr_nxt      = addr_r;
    rd_vld_nxt    = cmd.issue;
    rd_idx_nxt    = addr_r;
    total_nxt     = total_r;
    any_nxt       = any_r;
    last_cand_nxt = last_cand_r;
    prod_nxt      = prod_r;
    cum_nxt       = cum_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    chosen_nxt    = chosen_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_SEED_NODES:     seed_nxt  = cfg_wdata;
        CFG_LINKS_PER_NODE: links_nxt = cfg_wdata;
        default:            seed_nxt  = seed_r;
      endcase
    end

    if (cmd.load) frac_nxt = frac_in;
    if (cmd.init_sum) begin
      addr_nxt  = '0;
      total_nxt = '0;
      any_nxt   = 1'b0;
    end
    if (cmd.init_find) begin
      addr_nxt  = '0;
      cum_nxt   = '0;
      found_nxt = 1'b0;
    end
    if (cmd.clr_step || cmd.issue) addr_nxt = addr_r + 1'b1;

    if (cmd.acc_sum && cand) begin
      total_nxt     = total_r + TOT_W'(rd_deg);
      any_nxt       = 1'b1;
      last_cand_nxt = rd_idx_r;
    end
    if (cmd.mul) prod_nxt = PROD_W'(frac_r) * PROD_W'(total_r);
    if (cmd.acc_find && cand && !found_r) begin
      cum_nxt = cum_add;
      if ({cum_add, FRAC_W'(0)} > prod_r) begin
        found_nxt     = 1'b1;
        found_idx_nxt = rd_idx_r;
      end
    end
    if (cmd.rd_ch) chosen_nxt = found_r ? found_idx_r : last_cand_r;

    if (cmd.open_seed) begin
      current_nxt = NODE_W'(seed_eff);
      made_nxt    = '0;
      done_nxt    = NODE_W'(seed_eff) >= NODE_END;
    end
    if (cmd.open_next || (cmd.emit && node_full)) begin
      current_nxt = current_r + 1'b1;
      made_nxt    = '0;
      done_nxt    = (current_r + 1'b1) >= NODE_END;
    end else if (cmd.emit) begin
      made_nxt = made_inc;
    end
  end

  always_comb begin
    out_vld_nxt    = out_vld_r && !out_ready;
    out_new_nxt    = out_new_r;
    out_chosen_nxt = out_chosen_r;
    out_last_nxt   = out_last_r;
    if (cmd.emit) begin
      out_vld_nxt    = 1'b1;
      out_new_nxt    = OUT_W'(current_r);
      out_chosen_nxt = OUT_W'(chosen_r);
      out_last_nxt   = node_full && (current_r == NODE_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= 7'd3;
      links_r   <= 7'd2;
      current_r <= '0;
      made_r    <= '0;
      done_r    <= 1'b1;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      seed_r    <= seed_nxt;
      links_r   <= links_nxt;
      current_r <= current_nxt;
      made_r    <= made_nxt;
      done_r    <= done_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frac_r       <= frac_nxt;
    addr_r       <= addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    total_r      <= total_nxt;
    any_r        <= any_nxt;
    last_cand_r  <= last_cand_nxt;
    prod_r       <= prod_nxt;
    cum_r        <= cum_nxt;
    found_r      <= found_nxt;
    found_idx_r  <= found_idx_nxt;
    chosen_r     <= chosen_nxt;
    out_new_r    <= out_new_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign sts.addr_last = addr_r == IDX_LAST;
  assign sts.done      = done_r;
  assign sts.any       = any_r;
  assign sts.found     = found_r;
  assign sts.out_free  = !out_vld_r || out_ready;

  assign out_valid  = out_vld_r;
  assign out_new    = out_new_r;
  assign out_chosen = out_chosen_r;
  assign out_last   = out_last_r;

endmodule

[hw/rtl/preferential_attachment_linker.sv]
// Preferential-attachment linker. A start item (in_tuser low) rewrites the
// whole degree memory in one sweep of all addresses, giving each of the seed
// nodes a degree of one less than the seed count, and makes the first node
// after the seed clique current; it yields no result. Each draw item (in_tuser
// high) carries a Q0.16 random fraction in in_tdata and links the current node
// to one earlier node picked with probability proportional to its degree.
// A draw makes two scan passes, each reading one memory entry per cycle:
// the first sums the candidate degrees, the second stops at the first node
// whose running sum crosses fraction times total. A read and write of the
// chosen node and then of the current node update both degrees through
// the single memory port, and only then is the result offered.
// The degree memory has no reset of its own; it holds meaningful data only
// after the first start item, and draws before that are dropped. A result
// leaves through an output register, so the next item is taken while a
// result still waits. last_link travels as out_tlast and marks the final
// link of the whole graph.
module preferential_attachment_linker
  import pal_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,

  // Configuration write port: index 0 seed_nodes, index 1 links_per_node.
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,

  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // [15:0] rand_fraction
  input  logic             in_tuser,   // [0] mode

  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // [5:0] new_node, [11:6] chosen_node, zero above
  output logic             out_tlast   // last_link
);

  cmd_t             cmd;
  sts_t             sts;
  logic [OUT_W-1:0] out_new, out_chosen;

  pal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pal_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .frac_in    (in_tdata[FRAC_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_new    (out_new),
    .out_chosen (out_chosen),
    .out_last   (out_tlast),
    .out_ready  (out_tready)
  );

  // Fields packed from the lowest bit up; the top nibble is padding.
  assign out_tdata = {4'b0000, out_chosen, out_new};

endmodule
